// ===== hdl/glcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcw_pkg
// shared constants and types of the grid line collision walker
// ----------------------------------------------------------------------------
package glcw_pkg;

  localparam int DEF_MAP_SIDE   = 256;
  localparam int DEF_COORD_BITS = 11;

  localparam int CELL_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_W      = 9;
  localparam int VISIT_W    = 12;

  localparam logic [VISIT_W-1:0] VISIT_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_THRESH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRACE_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRACE_VALUE  = 3'd4;

  localparam logic [DIM_W-1:0]  RST_MAP_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]  RST_MAP_HEIGHT = 9'd256;
  localparam logic [CELL_W-1:0] RST_OCC_THRESH = 8'd1;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef struct packed {
    logic load;
    logic advance;
  } step_ctrl_t;

endpackage

// ===== hdl/glcw_grid_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcw_grid_ram
// occupancy grid store, one write port and one registered read port
// ----------------------------------------------------------------------------
module glcw_grid_ram
  import glcw_pkg::*;
#(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/glcw_line_stepper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcw_line_stepper
// integer line stepper, produces one cell position per advance
// ----------------------------------------------------------------------------
module glcw_line_stepper
  import glcw_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  step_ctrl_t                   ctrl,
  input  logic signed [COORD_BITS-1:0] ld_x0,
  input  logic signed [COORD_BITS-1:0] ld_y0,
  input  logic signed [COORD_BITS-1:0] ld_x1,
  input  logic signed [COORD_BITS-1:0] ld_y1,
  output logic signed [COORD_BITS-1:0] cur_x,
  output logic signed [COORD_BITS-1:0] cur_y,
  output logic                         cur_last
);

  // error term needs room for twice the largest span plus sign
  localparam int SW = COORD_BITS + 4;

  logic signed [COORD_BITS-1:0] x_r, y_r, x1_r, y1_r;
  logic signed [COORD_BITS-1:0] x_nxt, y_nxt;
  logic signed [SW-1:0]         dx_r, dy_r, err_r;
  logic signed [SW-1:0]         dx_nxt, dy_nxt, err_nxt;
  logic                         sx_r, sy_r;
  logic signed [SW-1:0]         diff_x, diff_y, e2;
  logic [COORD_BITS-1:0]        x_step, y_step;

  always_comb begin
    diff_x  = SW'(ld_x1) - SW'(ld_x0);
    diff_y  = SW'(ld_y1) - SW'(ld_y0);
    e2      = err_r <<< 1;
    x_step  = sx_r ? COORD_BITS'(1) : '1;
    y_step  = sy_r ? COORD_BITS'(1) : '1;
    x_nxt   = x_r;
    y_nxt   = y_r;
    err_nxt = err_r;
    dx_nxt  = diff_x[SW-1] ? -diff_x : diff_x;
    dy_nxt  = diff_y[SW-1] ? diff_y : -diff_y;
    if (ctrl.load) begin
      x_nxt   = ld_x0;
      y_nxt   = ld_y0;
      err_nxt = dx_nxt + dy_nxt;
    end else if (ctrl.advance) begin
      if (e2 > dy_r) begin
        err_nxt = err_nxt + dy_r;
        x_nxt   = x_r + x_step;
      end
      if (e2 < dx_r) begin
        err_nxt = err_nxt + dx_r;
        y_nxt   = y_r + y_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    err_r <= err_nxt;
    if (ctrl.load) begin
      x1_r <= ld_x1;
      y1_r <= ld_y1;
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      sx_r <= ld_x0 < ld_x1;
      sy_r <= ld_y0 < ld_y1;
    end
  end

  assign cur_x    = x_r;
  assign cur_y    = y_r;
  assign cur_last = (x_r == x1_r) && (y_r == y1_r);

endmodule

// ===== hdl/grid_line_collision_walker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_line_collision_walker_core
// byte occupancy grid with line-of-sight walk over the stored cells
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. A write
// request stores cell_value into the grid (when the cell is inside the map);
// its result strobes on out_valid in the next cycle and busy stays low.
// A check request walks the line from start to end cell, one cell per cycle
// through the grid memory read port, while busy is high. The cell read in one
// cycle is tested (and traced) in the next. The walk steps over off-map
// cells as well and ends at the blocking cell or the end cell; busy falls
// with the result strobe, and the next request can be taken in the cycle
// the result is shown. A check whose start lies outside the map answers in
// the next cycle.
// Results are on out_* for exactly one cycle with out_valid; the receiver
// cannot stall, so nothing is ever held back.
// The configuration channel (cfg_valid/cfg_ready, index and data) is always
// ready; the user must write it only while no request is in progress, and
// the block does not enforce this. Reset clears the control state and the
// configuration registers; the grid content is undefined until each cell is
// written.
// ----------------------------------------------------------------------------
module grid_line_collision_walker_core
  import glcw_pkg::*;
#(
  parameter int MAP_SIDE   = DEF_MAP_SIDE,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic                         in_pass_through,
  input  logic [CELL_W-1:0]            in_cell_value,

  output logic                         out_valid,
  output logic                         out_line_free,
  output logic                         out_start_outside,
  output logic [VISIT_W-1:0]           out_cells_visited,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int XB     = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
  localparam int ADDR_W = $clog2(MAP_SIDE * MAP_SIDE);
  localparam int SIDE_W = $clog2(MAP_SIDE + 1);
  localparam int WW     = (SIDE_W > DIM_W) ? SIDE_W : DIM_W;
  localparam int BW     = ((COORD_BITS > WW) ? COORD_BITS : WW) + 1;

  localparam logic [WW-1:0]     SIDE_LIM = WW'(MAP_SIDE);
  localparam logic [ADDR_W-1:0] SIDE_A   = ADDR_W'(MAP_SIDE);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  // configuration registers
  logic [DIM_W-1:0]  map_width_r, map_height_r;
  logic [CELL_W-1:0] occ_thresh_r, trace_value_r;
  logic              trace_en_r;

  // control and result registers
  state_t             state_r, state_nxt;
  logic               step_act_r, step_act_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic               pend_inmap_r, pend_inmap_nxt;
  logic               pend_last_r, pend_last_nxt;
  logic [ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic               ignore_r, ignore_nxt;
  logic [VISIT_W-1:0] visited_r, visited_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free_r, out_free_nxt;
  logic               out_outside_r, out_outside_nxt;
  logic [VISIT_W-1:0] out_visited_r, out_visited_nxt;

  logic [WW-1:0]      eff_w, eff_h;
  logic               accept, start_in_map;
  logic [ADDR_W-1:0]  start_addr;
  logic               cur_in_map, cur_last, occ;
  logic [VISIT_W-1:0] visited_inc;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  step_ctrl_t         step_ctrl;

  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [CELL_W-1:0]  wr_data, rd_data;

  function automatic logic in_map(input logic signed [COORD_BITS-1:0] x,
                                  input logic signed [COORD_BITS-1:0] y,
                                  input logic [WW-1:0] w,
                                  input logic [WW-1:0] h);
    logic [BW-1:0] xe, ye;
    xe = BW'(unsigned'(x));
    ye = BW'(unsigned'(y));
    return !x[COORD_BITS-1] && !y[COORD_BITS-1] && (xe < BW'(w)) && (ye < BW'(h));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [COORD_BITS-1:0] x,
                                                  input logic signed [COORD_BITS-1:0] y);
    logic [BW-1:0] xe, ye;
    xe = BW'(unsigned'(x));
    ye = BW'(unsigned'(y));
    return ADDR_W'(ye[XB-1:0]) * SIDE_A + ADDR_W'(xe[XB-1:0]);
  endfunction

  // configuration write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r   <= RST_MAP_WIDTH;
      map_height_r  <= RST_MAP_HEIGHT;
      occ_thresh_r  <= RST_OCC_THRESH;
      trace_en_r    <= 1'b0;
      trace_value_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:    map_width_r   <= cfg_data[DIM_W-1:0];
        REG_MAP_HEIGHT:   map_height_r  <= cfg_data[DIM_W-1:0];
        REG_OCC_THRESH:   occ_thresh_r  <= cfg_data[CELL_W-1:0];
        REG_TRACE_ENABLE: trace_en_r    <= cfg_data[0];
        REG_TRACE_VALUE:  trace_value_r <= cfg_data[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_w = (WW'(map_width_r) > SIDE_LIM) ? SIDE_LIM : WW'(map_width_r);
  assign eff_h = (WW'(map_height_r) > SIDE_LIM) ? SIDE_LIM : WW'(map_height_r);

  assign busy         = (state_r != S_IDLE);
  assign accept       = start && !busy;
  assign start_in_map = in_map(in_start_x, in_start_y, eff_w, eff_h);
  assign start_addr   = cell_addr(in_start_x, in_start_y);

  glcw_line_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk      (clk),
    .ctrl     (step_ctrl),
    .ld_x0    (in_start_x),
    .ld_y0    (in_start_y),
    .ld_x1    (in_end_x),
    .ld_y1    (in_end_y),
    .cur_x    (cur_x),
    .cur_y    (cur_y),
    .cur_last (cur_last)
  );

  assign cur_in_map  = in_map(cur_x, cur_y, eff_w, eff_h);
  assign occ         = rd_data >= occ_thresh_r;
  assign visited_inc = (visited_r == VISIT_MAX) ? visited_r : visited_r + VISIT_W'(1);

  always_comb begin
    state_nxt       = state_r;
    step_act_nxt    = step_act_r;
    pend_valid_nxt  = 1'b0;
    pend_inmap_nxt  = pend_inmap_r;
    pend_last_nxt   = pend_last_r;
    pend_addr_nxt   = pend_addr_r;
    ignore_nxt      = ignore_r;
    visited_nxt     = visited_r;
    out_valid_nxt   = 1'b0;
    out_free_nxt    = out_free_r;
    out_outside_nxt = out_outside_r;
    out_visited_nxt = out_visited_r;
    step_ctrl       = '0;
    wr_en           = 1'b0;
    wr_addr         = pend_addr_r;
    wr_data         = trace_value_r;
    rd_en           = 1'b0;
    rd_addr         = cell_addr(cur_x, cur_y);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_WRITE) begin
            wr_en           = start_in_map;
            wr_addr         = start_addr;
            wr_data         = in_cell_value;
            out_valid_nxt   = 1'b1;
            out_free_nxt    = 1'b0;
            out_outside_nxt = !start_in_map;
            out_visited_nxt = '0;
          end else if (!start_in_map) begin
            out_valid_nxt   = 1'b1;
            out_free_nxt    = 1'b0;
            out_outside_nxt = 1'b1;
            out_visited_nxt = '0;
          end else begin
            step_ctrl.load = 1'b1;
            step_act_nxt   = 1'b1;
            visited_nxt    = '0;
            ignore_nxt     = in_pass_through;
            state_nxt      = S_WALK;
          end
        end
      end
      S_WALK: begin
        // issue stage: read the current cell, then step on
        if (step_act_r) begin
          rd_en             = cur_in_map;
          pend_valid_nxt    = 1'b1;
          pend_inmap_nxt    = cur_in_map;
          pend_last_nxt     = cur_last;
          pend_addr_nxt     = rd_addr;
          step_ctrl.advance = !cur_last;
          step_act_nxt      = !cur_last;
        end
        // test stage: cell read in the previous cycle
        if (pend_valid_r) begin
          if (pend_inmap_r) begin
            visited_nxt = visited_inc;
            wr_en       = trace_en_r;
          end
          if ((pend_inmap_r && occ && !ignore_r) || pend_last_r) begin
            state_nxt       = S_IDLE;
            step_act_nxt    = 1'b0;
            pend_valid_nxt  = 1'b0;
            out_valid_nxt   = 1'b1;
            out_free_nxt    = !(pend_inmap_r && occ && !ignore_r);
            out_outside_nxt = 1'b0;
            out_visited_nxt = pend_inmap_r ? visited_inc : visited_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pend_inmap_r  <= pend_inmap_nxt;
    pend_last_r   <= pend_last_nxt;
    pend_addr_r   <= pend_addr_nxt;
    ignore_r      <= ignore_nxt;
    visited_r     <= visited_nxt;
    out_free_r    <= out_free_nxt;
    out_outside_r <= out_outside_nxt;
    out_visited_r <= out_visited_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_act_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_act_r   <= step_act_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  glcw_grid_ram #(
    .ADDR_W (ADDR_W)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid         = out_valid_r;
  assign out_line_free     = out_free_r;
  assign out_start_outside = out_outside_r;
  assign out_cells_visited = out_visited_r;

  // an accepted request either answers next cycle or starts a walk
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r || state_r == S_WALK))
    else $error("accepted request neither answered nor walking");

  // a result strobe always leaves the block ready for the next request
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe while walking");

  // the test stage only carries a cell while a walk is in progress
  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r || step_act_r) |-> state_r == S_WALK)
    else $error("walk pipeline active outside a walk");

  // a request with an outside start never reports free or visited cells
  a_outside_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_start_outside) |-> (!out_line_free && out_cells_visited == '0))
    else $error("outside start reported free or with visits");

endmodule
